// File: hw/rtl/itc_pkg.sv
// shared constants and types for the interval timer counter
package itc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int BYTE_WIDTH = 8;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BYTE_WIDTH-1:0] byte_t;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    localparam logic [1:0] PORT_DATA = 2'd0;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    localparam logic [1:0] SEL_COUNTER0 = 2'd0;
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOHI = 2'd3;

    localparam logic [2:0] MODE_ONE_SHOT = 3'd0;
    localparam logic [1:0] MODE_RATE_LOW = 2'd2;

    localparam byte_t BYTE_MASK = 8'hff;

endpackage

// File: hw/rtl/interval_timer_counter_top.sv
// interval timer counter 0: input stage, state update and result register
//
//   channel | handshake           | fields
//   input   | in_valid, in_stall  | kind, port, write_data
//   result  | out_valid, out_stall| read_data, out_level, irq_edge
//
// one result per transaction; a transaction passes the input stage register and then the result register
// one transaction per cycle sustained while out_stall is low, the state update being one combinational step
// rst_n clears the input and result valid flags and all timer state
// a stalled result register holds its transaction; the input stage still
// takes one more transaction, then in_stall rises until the result is taken
module interval_timer_counter_top
    import itc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [1:0] port,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       out_level,
    output logic       irq_edge
);

    // input stage
    logic       s1_valid_reg;
    logic [1:0] s1_kind_reg;
    logic [1:0] s1_port_reg;
    byte_t      s1_data_reg;

    // result stage
    logic  out_valid_reg;
    byte_t read_data_reg;
    logic  out_level_reg;
    logic  irq_edge_reg;

    // timer state
    logic   periodic_mode_reg, periodic_mode_next;
    count_t reload_value_reg, reload_value_next;
    count_t count_value_reg, count_value_next;
    logic   load_pending_reg, load_pending_next;
    logic   counting_reg, counting_next;
    logic   write_high_reg, write_high_next;
    byte_t  low_byte_hold_reg, low_byte_hold_next;
    logic   read_high_reg, read_high_next;
    count_t latched_value_reg, latched_value_next;
    logic   latch_held_reg, latch_held_next;
    logic   line_level_reg, line_level_next;

    byte_t  read_data_next;
    logic   irq_edge_next;

    logic   out_free;
    logic   s1_go;
    logic   in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_go     = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_port_reg <= port;
            s1_data_reg <= write_data;
        end
    end

    // count assembly and byte selection
    logic [15:0]             written_word;
    logic [COUNT_WIDTH+15:0] written_ext;
    count_t                  read_source;
    logic [COUNT_WIDTH+15:0] read_ext;
    count_t                  count_dec;

    assign written_word = {s1_data_reg, low_byte_hold_reg};
    assign written_ext  = {COUNT_WIDTH'(0), written_word};
    assign read_source  = latch_held_reg ? latched_value_reg : count_value_reg;
    assign read_ext     = {16'(0), read_source};
    assign count_dec    = count_value_reg - COUNT_WIDTH'(1);

    always_comb
    begin
        periodic_mode_next = periodic_mode_reg;
        reload_value_next  = reload_value_reg;
        count_value_next   = count_value_reg;
        load_pending_next  = load_pending_reg;
        counting_next      = counting_reg;
        write_high_next    = write_high_reg;
        low_byte_hold_next = low_byte_hold_reg;
        read_high_next     = read_high_reg;
        latched_value_next = latched_value_reg;
        latch_held_next    = latch_held_reg;
        line_level_next    = line_level_reg;
        read_data_next     = '0;
        irq_edge_next      = 1'b0;

        case (s1_kind_reg)
            KIND_TICK:
            begin
                if (load_pending_reg)
                begin
                    count_value_next  = reload_value_reg;
                    load_pending_next = 1'b0;
                    counting_next     = 1'b1;
                end
                else if (counting_reg)
                begin
                    if (!periodic_mode_reg)
                    begin
                        count_value_next = count_dec;
                        if (count_dec == '0)
                        begin
                            line_level_next = 1'b1;
                        end
                    end
                    else if (count_value_reg == COUNT_WIDTH'(1))
                    begin
                        count_value_next = reload_value_reg;
                        line_level_next  = 1'b1;
                    end
                    else
                    begin
                        count_value_next = count_dec;
                        if (count_dec == COUNT_WIDTH'(1))
                        begin
                            line_level_next = 1'b0;
                        end
                    end
                    irq_edge_next = !line_level_reg && line_level_next;
                end
            end
            KIND_WRITE:
            begin
                if (s1_port_reg == PORT_CTRL && s1_data_reg[7:6] == SEL_COUNTER0)
                begin
                    if (s1_data_reg[5:4] == ACC_LATCH)
                    begin
                        if (!latch_held_reg)
                        begin
                            latched_value_next = count_value_reg;
                            latch_held_next    = 1'b1;
                        end
                    end
                    else if (s1_data_reg[5:4] == ACC_LOHI && !s1_data_reg[0] &&
                             (s1_data_reg[3:1] == MODE_ONE_SHOT ||
                              s1_data_reg[2:1] == MODE_RATE_LOW))
                    begin
                        periodic_mode_next = (s1_data_reg[3:1] != MODE_ONE_SHOT);
                        line_level_next    = (s1_data_reg[3:1] != MODE_ONE_SHOT);
                        counting_next      = 1'b0;
                        load_pending_next  = 1'b0;
                        write_high_next    = 1'b0;
                        read_high_next     = 1'b0;
                        latch_held_next    = 1'b0;
                    end
                end
                else if (s1_port_reg == PORT_DATA)
                begin
                    if (!write_high_reg)
                    begin
                        low_byte_hold_next = s1_data_reg & BYTE_MASK;
                        write_high_next    = 1'b1;
                        if (!periodic_mode_reg)
                        begin
                            counting_next     = 1'b0;
                            load_pending_next = 1'b0;
                            line_level_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        write_high_next   = 1'b0;
                        reload_value_next = written_ext[COUNT_WIDTH-1:0];
                        if (!periodic_mode_reg || !counting_reg)
                        begin
                            load_pending_next = 1'b1;
                        end
                    end
                end
            end
            KIND_READ:
            begin
                if (s1_port_reg == PORT_DATA)
                begin
                    if (!read_high_reg)
                    begin
                        read_data_next = read_ext[7:0];
                        read_high_next = 1'b1;
                    end
                    else
                    begin
                        read_data_next  = read_ext[15:8];
                        read_high_next  = 1'b0;
                        latch_held_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_mode_reg <= 1'b0;
            reload_value_reg  <= '0;
            count_value_reg   <= '0;
            load_pending_reg  <= 1'b0;
            counting_reg      <= 1'b0;
            write_high_reg    <= 1'b0;
            low_byte_hold_reg <= '0;
            read_high_reg     <= 1'b0;
            latched_value_reg <= '0;
            latch_held_reg    <= 1'b0;
            line_level_reg    <= 1'b0;
        end
        else if (s1_go)
        begin
            periodic_mode_reg <= periodic_mode_next;
            reload_value_reg  <= reload_value_next;
            count_value_reg   <= count_value_next;
            load_pending_reg  <= load_pending_next;
            counting_reg      <= counting_next;
            write_high_reg    <= write_high_next;
            low_byte_hold_reg <= low_byte_hold_next;
            read_high_reg     <= read_high_next;
            latched_value_reg <= latched_value_next;
            latch_held_reg    <= latch_held_next;
            line_level_reg    <= line_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            read_data_reg <= read_data_next;
            out_level_reg <= line_level_next;
            irq_edge_reg  <= irq_edge_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign out_level = out_level_reg;
    assign irq_edge  = irq_edge_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input stage");

    a_irq_with_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && irq_edge_reg) |-> out_level_reg)
        else $error("interrupt edge without high output");

    a_load_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_kind_reg == KIND_TICK && load_pending_reg)
        |=> (!load_pending_reg && counting_reg))
        else $error("pending load not taken on tick");

    a_latch_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_kind_reg == KIND_WRITE && s1_port_reg == PORT_CTRL &&
         s1_data_reg[7:4] == 4'h0) |=> latch_held_reg)
        else $error("latch command did not hold a count");

    a_result_after_go: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> out_valid_reg)
        else $error("processed transaction lost before result register");

endmodule

// File: test/itc_result_checker.sv
// result checker for the interval timer counter: tracks timer state per transaction and compares
module itc_result_checker
    import itc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] kind,
    input  logic [1:0] port,
    input  logic [7:0] write_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] read_data,
    input  logic       out_level,
    input  logic       irq_edge,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        byte_t read_data;
        logic  out_level;
        logic  irq_edge;
    } timer_result_t;

    timer_result_t pending_timer_results[$];
    int            mismatches;

    logic   rate_mode;
    count_t reload_count;
    count_t live_count;
    logic   load_waiting;
    logic   running;
    logic   expect_high_write;
    byte_t  held_low_byte;
    logic   expect_high_read;
    count_t latch_count;
    logic   latch_valid;
    logic   line;

    function automatic void apply_control(byte_t w);
        if (w[7:6] != SEL_COUNTER0)
            return;
        if (w[5:4] == ACC_LATCH)
        begin
            if (!latch_valid)
            begin
                latch_count = live_count;
                latch_valid = 1'b1;
            end
            return;
        end
        if (w[5:4] != ACC_LOHI || w[0])
            return;
        if (w[3:1] == MODE_ONE_SHOT)
        begin
            rate_mode = 1'b0;
            line = 1'b0;
        end
        else if (w[2:1] == MODE_RATE_LOW)
        begin
            rate_mode = 1'b1;
            line = 1'b1;
        end
        else
            return;
        running = 1'b0;
        load_waiting = 1'b0;
        expect_high_write = 1'b0;
        expect_high_read = 1'b0;
        latch_valid = 1'b0;
    endfunction

    function automatic void apply_data_write(byte_t b);
        if (!expect_high_write)
        begin
            held_low_byte = b;
            expect_high_write = 1'b1;
            if (!rate_mode)
            begin
                running = 1'b0;
                load_waiting = 1'b0;
                line = 1'b0;
            end
        end
        else
        begin
            expect_high_write = 1'b0;
            reload_count = count_t'({b, held_low_byte});
            if (!rate_mode || !running)
                load_waiting = 1'b1;
        end
    endfunction

    function automatic byte_t take_read_byte();
        count_t v;
        byte_t  r;
        v = latch_valid ? latch_count : live_count;
        if (!expect_high_read)
        begin
            r = v[7:0];
            expect_high_read = 1'b1;
        end
        else
        begin
            r = v[15:8];
            expect_high_read = 1'b0;
            latch_valid = 1'b0;
        end
        return r;
    endfunction

    // returns 1 when the output line rose on this tick
    function automatic logic advance_count();
        logic was;
        was = line;
        if (load_waiting)
        begin
            live_count = reload_count;
            load_waiting = 1'b0;
            running = 1'b1;
            return 1'b0;
        end
        if (!running)
            return 1'b0;
        if (!rate_mode)
        begin
            live_count = live_count - 1'b1;
            if (live_count == '0)
                line = 1'b1;
        end
        else if (live_count == count_t'(1))
        begin
            live_count = reload_count;
            line = 1'b1;
        end
        else
        begin
            live_count = live_count - 1'b1;
            if (live_count == count_t'(1))
                line = 1'b0;
        end
        return !was && line;
    endfunction

    function automatic timer_result_t next_timer_result(logic [1:0] k, logic [1:0] p, byte_t d);
        timer_result_t r;
        r = '0;
        if (k == KIND_TICK)
            r.irq_edge = advance_count();
        else if (k == KIND_WRITE)
        begin
            if (p == PORT_CTRL)
                apply_control(d);
            else if (p == PORT_DATA)
                apply_data_write(d);
        end
        else if (k == KIND_READ && p == PORT_DATA)
            r.read_data = take_read_byte();
        r.out_level = line;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        timer_result_t want;
        if (!rst_n)
        begin
            pending_timer_results.delete();
            mismatches = 0;
            rate_mode = 1'b0;
            reload_count = '0;
            live_count = '0;
            load_waiting = 1'b0;
            running = 1'b0;
            expect_high_write = 1'b0;
            held_low_byte = '0;
            expect_high_read = 1'b0;
            latch_count = '0;
            latch_valid = 1'b0;
            line = 1'b0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_timer_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction: expected none actual %h/%b/%b",
                             $time, read_data, out_level, irq_edge);
                    mismatches++;
                end
                else
                begin
                    want = pending_timer_results.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data mismatch: expected %h actual %h",
                                 $time, want.read_data, read_data);
                        mismatches++;
                    end
                    if (out_level !== want.out_level)
                    begin
                        $display("%0t: out_level mismatch: expected %b actual %b",
                                 $time, want.out_level, out_level);
                        mismatches++;
                    end
                    if (irq_edge !== want.irq_edge)
                    begin
                        $display("%0t: irq_edge mismatch: expected %b actual %b",
                                 $time, want.irq_edge, irq_edge);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_timer_results.push_back(next_timer_result(kind, port, write_data));
            fail_count <= mismatches;
            outstanding <= pending_timer_results.size();
        end
    end

endmodule

// File: test/tb_interval_timer_counter_top.sv
// testbench top for the interval timer counter: stimulus, flow control and verdict
module tb_interval_timer_counter_top;
    import itc_pkg::*;

    localparam logic [1:0] ACC_LOW_ONLY = 2'd1;
    localparam logic [1:0] SEL_READBACK = 2'd3;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PERCENT = 19;
    localparam int STEADY_FROM = 200;
    localparam int STEADY_TO = 270;
    localparam int PAUSE_AT = 320;
    localparam int HOLD_AFTER_RESULTS = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 4;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    kind_t kind = KIND_TICK;
    logic [1:0] port = PORT_DATA;
    byte_t write_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    byte_t read_data;
    logic  out_level;
    logic  irq_edge;

    int   fail_count;
    int   outstanding;
    int   items_sent = 0;
    int   results_taken = 0;
    int   quiet_cycles = 0;
    logic steady = 1'b0;
    logic held_off = 1'b0;

    always #10 clk = ~clk;

    interval_timer_counter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .port       (port),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .out_level  (out_level),
        .irq_edge   (irq_edge)
    );

    itc_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .port        (port),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .out_level   (out_level),
        .irq_edge    (irq_edge),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    task automatic send_item(input kind_t k, input logic [1:0] p, input byte_t d);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        port <= p;
        write_data <= d;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 2'($urandom_range(3)), byte_t'($urandom));
    endtask

    task automatic send_noise();
        send_item(kind_t'($urandom_range(2)), 2'($urandom_range(3)), byte_t'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            results_taken <= results_taken + 1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_interval_timer_counter_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, one long hold-off, none during the steady stretch
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_taken >= HOLD_AFTER_RESULTS)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial
    begin : stimulus
        int    random_base;
        int    steps;
        int    pick;
        logic  paused;
        byte_t ctrl;
        byte_t lo;
        byte_t hi;

        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-shot with count one: terminal count, then wrap
        send_item(KIND_READ, PORT_DATA, 8'h00);
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LOHI, MODE_ONE_SHOT, 1'b0});
        send_item(KIND_WRITE, PORT_DATA, 8'h01);
        send_item(KIND_WRITE, PORT_DATA, 8'h00);
        repeat (3) send_tick();
        // second latch before the read completes is ignored
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LATCH, 4'h0});
        send_tick();
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LATCH, 4'hf});
        repeat (2) send_item(KIND_READ, PORT_DATA, 8'hff);
        // rate generator, new count while counting, then count one
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LOHI, 1'b1, MODE_RATE_LOW, 1'b0});
        send_item(KIND_WRITE, PORT_DATA, 8'h02);
        send_item(KIND_WRITE, PORT_DATA, 8'h00);
        repeat (2) send_tick();
        send_item(KIND_WRITE, PORT_DATA, 8'h01);
        send_item(KIND_WRITE, PORT_DATA, 8'h00);
        repeat (2) send_tick();
        // words that must be ignored
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LOHI, MODE_ONE_SHOT, 1'b1});
        send_item(KIND_WRITE, PORT_CTRL, {SEL_READBACK, ACC_LOHI, MODE_ONE_SHOT, 1'b0});
        send_item(KIND_WRITE, PORT_CTRL, {SEL_COUNTER0, ACC_LOW_ONLY, MODE_ONE_SHOT, 1'b0});
        // zero count means full range
        send_item(KIND_WRITE, PORT_DATA, 8'h00);
        send_item(KIND_WRITE, PORT_DATA, 8'h00);
        repeat (2) send_tick();
        repeat (2) send_item(KIND_READ, PORT_DATA, 8'h00);

        random_base = items_sent;
        while (items_sent < random_base + RANDOM_ITEMS)
        begin
            steady <= (items_sent >= random_base + STEADY_FROM)
                      && (items_sent < random_base + STEADY_TO);
            if (!paused && items_sent >= random_base + PAUSE_AT)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(3) != 0)
                begin
                    ctrl = {SEL_COUNTER0, ACC_LOHI, MODE_ONE_SHOT, 1'b0};
                    if ($urandom_range(1) == 1)
                    begin
                        ctrl[3] = 1'($urandom_range(1));
                        ctrl[2:1] = MODE_RATE_LOW;
                    end
                    send_item(KIND_WRITE, PORT_CTRL, ctrl);
                end
                case ($urandom_range(9))
                    0:
                    begin
                        lo = byte_t'($urandom);
                        hi = byte_t'($urandom);
                    end
                    1:
                    begin
                        lo = 8'h00;
                        hi = 8'h00;
                    end
                    default:
                    begin
                        lo = byte_t'($urandom_range(1, 6));
                        hi = 8'h00;
                    end
                endcase
                send_item(KIND_WRITE, PORT_DATA, lo);
                send_item(KIND_WRITE, PORT_DATA, hi);
                steps = $urandom_range(4, 16);
                repeat (steps)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        send_tick();
                    else if (pick < 78)
                    begin
                        ctrl = byte_t'($urandom);
                        ctrl[7:6] = SEL_COUNTER0;
                        ctrl[5:4] = ACC_LATCH;
                        send_item(KIND_WRITE, PORT_CTRL, ctrl);
                    end
                    else if (pick < 92)
                        send_item(KIND_READ, PORT_DATA, byte_t'($urandom));
                    else if (pick < 97)
                        send_item(KIND_WRITE, PORT_DATA, byte_t'($urandom_range(0, 6)));
                    else
                        send_noise();
                end
            end
            else
                repeat ($urandom_range(1, 3)) send_noise();
        end

        steady <= 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_interval_timer_counter_top: PASS");
        else
            $display("tb_interval_timer_counter_top: FAIL");
        $finish;
    end

endmodule

// File: interval_timer_counter_top.f
hw/rtl/itc_pkg.sv
hw/rtl/interval_timer_counter_top.sv
test/itc_result_checker.sv
test/tb_interval_timer_counter_top.sv
